/* design/comment_line_counter_defines.svh */
// assertion macros for the comment line counter
// used by the top level, which provides clk_i and rst_ni
`ifndef COMMENT_LINE_COUNTER_DEFINES_SVH
`define COMMENT_LINE_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/clc_pkg.sv */
// shared types and constants of the comment line counter
// no dependencies
package clc_pkg;

  // byte codes the scanner looks at
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // depth of the queue between front and scanner
  localparam int unsigned QUEUE_DEPTH = 2;

  // classified word handed from the front to the scanner
  typedef struct packed {
    logic has_byte;
    logic end_of_file;
    logic is_ws;
    logic is_nl;
    logic is_slash;
    logic is_star;
  } clc_item_t;

  // which value goes into the comment count adder
  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_ONE,
    ADD_OCC,
    ADD_FREE,
    ADD_SPAN
  } add_sel_e;

endpackage

/* design/clc_in_if.sv */
// input channel of the comment line counter: one file byte per word
// no dependencies
interface clc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_byte;
  logic       end_of_file;

  modport source (output valid, output char_byte, output has_byte, output end_of_file,
                  input ready);
  modport sink   (input valid, input char_byte, input has_byte, input end_of_file,
                  output ready);
endinterface

/* design/clc_out_if.sv */
// output channel of the comment line counter: per-file counts and totals
// no dependencies
interface clc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_lines;
  logic [31:0] file_comment_lines;
  logic [31:0] all_lines;
  logic [31:0] all_comment_lines;
  logic [31:0] files_done;

  modport source (output valid, output file_lines, output file_comment_lines,
                  output all_lines, output all_comment_lines, output files_done,
                  input ready);
  modport sink   (input valid, input file_lines, input file_comment_lines,
                  input all_lines, input all_comment_lines, input files_done,
                  output ready);
endinterface

/* design/comment_line_counter.sv */
// top level of the comment line counter
// depends on clc_pkg, clc_in_if, clc_out_if, clc_front, clc_scan, clc_total
// and comment_line_counter_defines.svh
`include "comment_line_counter_defines.svh"

// Counts lines and comment lines of C-style source files streamed one byte
// per input word; a word with end_of_file set produces one result word with
// the file's counts and the running totals over all files. The block takes
// one word per clock cycle while the output does not stall: a two-word queue
// separates the byte classifier from the scanner, and the scanner updates the
// comment count with a single saturating adder per word. An end-of-file
// word passes from its queue slot into the scanner's finish register, then
// into the result register that drives the output. Words that do not end
// a file never wait on the output side; an end-of-file word waits at the
// head of the queue while both the finish register and the result register
// hold unaccepted results; the input stalls once the queue fills behind it.
// Counters are COUNT_WIDTH bits and saturate; results are clamped to 32 bits.
module comment_line_counter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clc_in_if.sink    in_ch_i,
  clc_out_if.source out_ch_o
);
  import clc_pkg::*;

  logic                    q_valid;
  logic                    q_pop;
  clc_item_t               q_item;
  logic                    fin_valid;
  logic                    fin_ready;
  logic [COUNT_WIDTH-1:0]  fin_lines;
  logic [COUNT_WIDTH-1:0]  fin_comment;

  // accept and classify
  clc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // per-file scanning
  clc_scan #(
    .CountWidth (COUNT_WIDTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .fin_valid_o   (fin_valid),
    .fin_ready_i   (fin_ready),
    .fin_lines_o   (fin_lines),
    .fin_comment_o (fin_comment)
  );

  // running totals and result word
  clc_total #(
    .CountWidth (COUNT_WIDTH)
  ) u_total (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_valid_i   (fin_valid),
    .fin_ready_o   (fin_ready),
    .fin_lines_i   (fin_lines),
    .fin_comment_i (fin_comment),
    .out_ch_o      (out_ch_o)
  );

  // a taken finish record shows up as a result word
  `CLC_ASSERT_NXT(a_fin_to_out, fin_valid && fin_ready, out_ch_o.valid, "finish record lost")
  // a stalled finish record stays
  `CLC_ASSERT_NXT(a_fin_hold, fin_valid && !fin_ready, fin_valid, "finish record dropped")
  // an end-of-file word only leaves the queue when the finish register has room
  `CLC_ASSERT_IMP(a_eof_room, q_pop && q_item.end_of_file, !fin_valid || fin_ready, "finish overrun")

endmodule

/* design/clc_front.sv */
// front end: accepts input words, classifies the byte, queues the result
// depends on clc_pkg and clc_in_if
module clc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  clc_in_if.sink              in_ch_i,
  output logic                q_valid_o,
  output clc_pkg::clc_item_t  q_item_o,
  input  logic                q_pop_i
);
  import clc_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  clc_item_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  clc_item_t           item;
  logic                push;
  logic [7:0]          c;

  // byte classification
  always_comb begin
    c                = in_ch_i.char_byte;
    item.has_byte    = in_ch_i.has_byte;
    item.end_of_file = in_ch_i.end_of_file;
    item.is_ws       = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    item.is_nl       = (c == CHAR_NL);
    item.is_slash    = (c == CHAR_SLASH);
    item.is_star     = (c == CHAR_STAR);
  end

  assign in_ch_i.ready = (cnt_q != CntW'(QUEUE_DEPTH));
  assign push          = in_ch_i.valid && in_ch_i.ready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

endmodule

/* design/clc_scan.sv */
// back end: per-file line and comment scanner, emits a finish record per file
// depends on clc_pkg
module clc_scan #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  clc_pkg::clc_item_t     q_item_i,
  output logic                   q_pop_o,
  output logic                   fin_valid_o,
  input  logic                   fin_ready_i,
  output logic [CountWidth-1:0]  fin_lines_o,
  output logic [CountWidth-1:0]  fin_comment_o
);
  import clc_pkg::*;

  localparam int unsigned W = CountWidth;
  localparam logic [W-1:0] CntMax = '1;

  // per-file state
  logic [W-1:0] line_q, line_d;
  logic [W-1:0] cmt_q, cmt_d;
  logic [W-1:0] aocc_q, aocc_d;    // block lines if code follows the close
  logic [W-1:0] afree_q, afree_d;  // block lines if the close ends the line
  logic started_q, started_d;
  logic blank_q, blank_d;
  logic inblk_q, inblk_d;
  logic occ_q, occ_d;
  logic hslash_q, hslash_d;
  logic hstar_q, hstar_d;
  logic skip_q, skip_d;
  logic cpend_q, cpend_d;

  // finish record register
  logic         fin_valid_q;
  logic [W-1:0] fin_lines_q, fin_cmt_q;

  logic         fin_free, pop, line_inc, opened, cin, proceed;
  add_sel_e     add_sel;
  logic [W-1:0] opnd, cmt_new, line_new;
  logic [W:0]   cmt_sum;
  clc_item_t    it;

  assign it       = q_item_i;
  assign fin_free = !fin_valid_q || fin_ready_i;
  assign pop      = q_valid_i && (!it.end_of_file || fin_free);
  assign q_pop_o  = pop;

  // next state of the scanner
  always_comb begin
    line_d    = line_q;
    cmt_d     = cmt_q;
    aocc_d    = aocc_q;
    afree_d   = afree_q;
    started_d = started_q;
    blank_d   = blank_q;
    inblk_d   = inblk_q;
    occ_d     = occ_q;
    hslash_d  = hslash_q;
    hstar_d   = hstar_q;
    skip_d    = skip_q;
    cpend_d   = cpend_q;
    add_sel   = ADD_NONE;
    line_inc  = 1'b0;
    opened    = 1'b0;
    proceed   = 1'b1;
    cin       = 1'b0;

    if (pop && it.has_byte) begin
      // a line counts at its first byte
      if (!started_q) begin
        started_d = 1'b1;
        line_inc  = (line_q != CntMax);
        line_d    = line_q + W'(line_inc);
        if (line_inc) begin
          afree_d = afree_q + W'(afree_q != CntMax);
          if (!occ_q || afree_q != '0) begin
            aocc_d = aocc_q + W'(aocc_q != CntMax);
          end
        end
      end

      if (it.is_nl) begin
        // line end settles a pending close as line-ending
        if (cpend_q) begin
          add_sel = ADD_FREE;
          occ_d   = 1'b0;
          cpend_d = 1'b0;
        end
        hslash_d  = 1'b0;
        hstar_d   = 1'b0;
        skip_d    = 1'b0;
        blank_d   = 1'b1;
        started_d = 1'b0;
      end else if (!skip_q) begin
        // code after a close
        if (cpend_q && !it.is_ws) begin
          add_sel = ADD_OCC;
          occ_d   = 1'b0;
          cpend_d = 1'b0;
        end
        if (inblk_q) begin
          if (hstar_q && it.is_slash) begin
            inblk_d = 1'b0;
            hstar_d = 1'b0;
            cpend_d = 1'b1;
          end else begin
            hstar_d = it.is_star;
          end
          if (!it.is_ws) begin
            blank_d = 1'b0;
          end
        end else begin
          if (hslash_q) begin
            hslash_d = 1'b0;
            if (it.is_star) begin
              // block comment opens
              inblk_d = 1'b1;
              opened  = 1'b1;
              occ_d   = occ_q || !blank_q;
              aocc_d  = '0;
              afree_d = W'(!(occ_q || !blank_q));
              blank_d = 1'b0;
              proceed = 1'b0;
            end else if (it.is_slash) begin
              if (blank_q) begin
                add_sel = ADD_ONE;
                skip_d  = 1'b1;
              end else begin
                hslash_d = 1'b1;
              end
              blank_d = 1'b0;
              proceed = 1'b0;
            end else begin
              blank_d = 1'b0;
            end
          end
          if (proceed) begin
            if (it.is_slash) begin
              hslash_d = 1'b1;
            end else if (!it.is_ws) begin
              blank_d = 1'b0;
            end
          end
        end
      end
    end

    // end of file closes any open block
    if (pop && it.end_of_file) begin
      if (cpend_d) begin
        add_sel = ADD_FREE;
      end else if (inblk_d) begin
        add_sel = ADD_SPAN;
        cin     = line_inc;
      end
    end

    // single saturating add into the comment count
    case (add_sel)
      ADD_ONE:  opnd = '0;
      ADD_OCC:  opnd = aocc_q;
      ADD_FREE: opnd = afree_q;
      ADD_SPAN: opnd = opened ? '0 : (occ_q ? afree_q : aocc_q);
      default:  opnd = '0;
    endcase
    if (add_sel == ADD_ONE) begin
      cin = 1'b1;
    end
    cmt_sum = {1'b0, cmt_q} + {1'b0, opnd} + (W+1)'(cin);
    cmt_new = cmt_sum[W] ? CntMax : cmt_sum[W-1:0];
    line_new = line_d;
    if (add_sel != ADD_NONE) begin
      cmt_d = cmt_new;
    end

    // per-file state returns to reset after a file
    if (pop && it.end_of_file) begin
      line_d    = '0;
      cmt_d     = '0;
      aocc_d    = '0;
      afree_d   = '0;
      started_d = 1'b0;
      blank_d   = 1'b1;
      inblk_d   = 1'b0;
      occ_d     = 1'b0;
      hslash_d  = 1'b0;
      hstar_d   = 1'b0;
      skip_d    = 1'b0;
      cpend_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      cmt_q       <= '0;
      aocc_q      <= '0;
      afree_q     <= '0;
      started_q   <= 1'b0;
      blank_q     <= 1'b1;
      inblk_q     <= 1'b0;
      occ_q       <= 1'b0;
      hslash_q    <= 1'b0;
      hstar_q     <= 1'b0;
      skip_q      <= 1'b0;
      cpend_q     <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      line_q    <= line_d;
      cmt_q     <= cmt_d;
      aocc_q    <= aocc_d;
      afree_q   <= afree_d;
      started_q <= started_d;
      blank_q   <= blank_d;
      inblk_q   <= inblk_d;
      occ_q     <= occ_d;
      hslash_q  <= hslash_d;
      hstar_q   <= hstar_d;
      skip_q    <= skip_d;
      cpend_q   <= cpend_d;
      if (fin_free) begin
        fin_valid_q <= pop && it.end_of_file;
      end
    end
  end

  // finish record payload
  always_ff @(posedge clk_i) begin
    if (pop && it.end_of_file) begin
      fin_lines_q <= line_new;
      fin_cmt_q   <= (add_sel != ADD_NONE) ? cmt_new : cmt_q;
    end
  end

  assign fin_valid_o   = fin_valid_q;
  assign fin_lines_o   = fin_lines_q;
  assign fin_comment_o = fin_cmt_q;

endmodule

/* design/clc_total.sv */
// running totals over all files and the registered result word
// depends on clc_out_if
module clc_total #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fin_valid_i,
  output logic                   fin_ready_o,
  input  logic [CountWidth-1:0]  fin_lines_i,
  input  logic [CountWidth-1:0]  fin_comment_i,
  clc_out_if.source              out_ch_o
);

  localparam int unsigned W = CountWidth;
  localparam logic [W-1:0] CntMax = '1;

  logic [W-1:0] sum_l_q, sum_l_d;
  logic [W-1:0] sum_c_q, sum_c_d;
  logic [W-1:0] files_q, files_d;
  logic [W:0]   sum_l_ext, sum_c_ext;
  logic         out_valid_q;
  logic [31:0]  o_fl_q, o_fc_q, o_al_q, o_ac_q, o_fd_q;
  logic         take;

  // clamp a counter to the 32-bit result field
  function automatic logic [31:0] clamp32(input logic [W-1:0] v);
    logic [63:0] x;
    x = 64'(v);
    return (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  assign fin_ready_o = !out_valid_q || out_ch_o.ready;
  assign take        = fin_valid_i && fin_ready_o;

  // saturating running sums
  always_comb begin
    sum_l_ext = {1'b0, sum_l_q} + {1'b0, fin_lines_i};
    sum_c_ext = {1'b0, sum_c_q} + {1'b0, fin_comment_i};
    sum_l_d   = sum_l_ext[W] ? CntMax : sum_l_ext[W-1:0];
    sum_c_d   = sum_c_ext[W] ? CntMax : sum_c_ext[W-1:0];
    files_d   = files_q + W'(files_q != CntMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q     <= '0;
      sum_c_q     <= '0;
      files_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        sum_l_q <= sum_l_d;
        sum_c_q <= sum_c_d;
        files_q <= files_d;
      end
      if (fin_ready_o) begin
        out_valid_q <= fin_valid_i;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (take) begin
      o_fl_q <= clamp32(fin_lines_i);
      o_fc_q <= clamp32(fin_comment_i);
      o_al_q <= clamp32(sum_l_d);
      o_ac_q <= clamp32(sum_c_d);
      o_fd_q <= clamp32(files_d);
    end
  end

  assign out_ch_o.valid              = out_valid_q;
  assign out_ch_o.file_lines         = o_fl_q;
  assign out_ch_o.file_comment_lines = o_fc_q;
  assign out_ch_o.all_lines          = o_al_q;
  assign out_ch_o.all_comment_lines  = o_ac_q;
  assign out_ch_o.files_done         = o_fd_q;

endmodule
